### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expr must hold at every clock edge out of reset
`define CHK_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// cons must hold at every clock edge where ante holds
`define CHK_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define CHK_ALWAYS(label, expr, msg)
`define CHK_IMPL(label, ante, cons, msg)

`endif

`endif

### rtl/lasct_pkg.sv
// ----------------------------------------------------------------------------
// lasct_pkg
// Sizes, word types and address helper for the local alignment scorer.
// ----------------------------------------------------------------------------
package lasct_pkg;

	localparam int MAX_LEN = 32;
	localparam int DIM     = MAX_LEN + 1;
	localparam int IDX_W   = $clog2(MAX_LEN);
	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int ADDR_W  = $clog2(DIM * DIM);
	localparam int SYM_W   = 8;
	localparam int SCORE_W = 9;
	localparam int CFG_W   = 5;
	localparam int CFGI_W  = 2;

	localparam logic [CFGI_W-1:0] REG_MATCH    = 2'd0;
	localparam logic [CFGI_W-1:0] REG_MISMATCH = 2'd1;
	localparam logic [CFGI_W-1:0] REG_GAP      = 2'd2;

	typedef logic [SYM_W-1:0]   sym_t;
	typedef logic [CNT_W-1:0]   pos_t;
	typedef logic [SCORE_W-1:0] score_t;
	typedef logic [ADDR_W-1:0]  addr_t;

	// row-major address of matrix cell (r, c)
	function automatic addr_t cell_addr(input pos_t r, input pos_t c);
		return ADDR_W'(r) * ADDR_W'(DIM) + ADDR_W'(c);
	endfunction

endpackage

### rtl/lasct_pair_if.sv
// ----------------------------------------------------------------------------
// lasct_pair_if
// Symbol pair channel: one word per pair of symbols, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lasct_pair_if;
	logic              valid;
	logic              ready;
	lasct_pkg::sym_t   symbol_first;
	lasct_pkg::sym_t   symbol_second;
	logic              final_pair;

	modport source (output valid, output symbol_first, output symbol_second,
		output final_pair, input ready);
	modport sink (input valid, input symbol_first, input symbol_second,
		input final_pair, output ready);
endinterface

### rtl/lasct_cell_if.sv
// ----------------------------------------------------------------------------
// lasct_cell_if
// Traceback channel: one word per path cell, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lasct_cell_if;
	logic              valid;
	logic              ready;
	lasct_pkg::pos_t   path_row;
	lasct_pkg::pos_t   path_col;
	lasct_pkg::score_t cell_score;
	logic              path_end;

	modport source (output valid, output path_row, output path_col,
		output cell_score, output path_end, input ready);
	modport sink (input valid, input path_row, input path_col,
		input cell_score, input path_end, output ready);
endinterface

### rtl/local_alignment_scorer_traceback.sv
// ----------------------------------------------------------------------------
// local_alignment_scorer_traceback
// Smith-Waterman local alignment, linear gap, with traceback output.
//
// pairs: one word per symbol pair, taken one per cycle while the block is
//   loading. Pairs past MAX_LEN are dropped; final_pair starts scoring.
// cells: traceback words from the best cell back to the alignment start,
//   path_end set on the last one. All-zero matrix gives the single cell (0,0).
// cfg: write-only registers match, mismatch and gap; the user writes them
//   when idle, which the block itself does not enforce. Scoring uses one
//   shared add/max unit and one single-port read of the score memory per
//   cell (read up neighbor, then compute and write). Traceback makes three
//   neighbor reads per path cell through the same port, then compares and
//   emits, waiting to emit while cells is stalled.
// pairs.ready is low from the final pair until the last traceback word is
//   loaded into the output register; that word may still wait there while
//   the next load starts.
// Reset: registers back to 2, -1, -1, load count zero, output empty. The
//   score memory needs no clearing; row and column zero are forced to zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module local_alignment_scorer_traceback (
	input  logic                                   clk,
	input  logic                                   arst_n,
	lasct_pair_if.sink                             pairs,
	lasct_cell_if.source                           cells,
	input  logic                                   cfg_we,
	input  logic [lasct_pkg::CFGI_W-1:0]           cfg_index,
	input  logic [lasct_pkg::CFG_W-1:0]            cfg_data
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_FRD  = 4'd1;
	localparam logic [3:0] S_FWR  = 4'd2;
	localparam logic [3:0] S_TSEL = 4'd3;
	localparam logic [3:0] S_TD   = 4'd4;
	localparam logic [3:0] S_TL   = 4'd5;
	localparam logic [3:0] S_TU   = 4'd6;
	localparam logic [3:0] S_TE   = 4'd7;
	localparam logic [3:0] S_ZERO = 4'd8;

	localparam int SW = lasct_pkg::SCORE_W + 2;

	logic [3:0]                        state_q;
	logic [3:0]                        match_q;
	logic [lasct_pkg::CFG_W-1:0]       mism_q;
	logic [lasct_pkg::CFG_W-1:0]       gap_q;

	lasct_pkg::pos_t                   cnt_q;
	lasct_pkg::pos_t                   n_q;
	lasct_pkg::pos_t                   i_q;
	lasct_pkg::pos_t                   j_q;
	lasct_pkg::score_t                 diag_q;
	lasct_pkg::score_t                 left_q;
	lasct_pkg::score_t                 best_q;
	lasct_pkg::pos_t                   best_row_q;
	lasct_pkg::pos_t                   best_col_q;
	lasct_pkg::score_t                 cur_q;
	lasct_pkg::score_t                 td_q;
	lasct_pkg::score_t                 tl_q;

	lasct_pkg::sym_t                   a_mem [0:lasct_pkg::MAX_LEN-1];
	lasct_pkg::sym_t                   b_mem [0:lasct_pkg::MAX_LEN-1];
	lasct_pkg::score_t                 h_mem [0:lasct_pkg::DIM*lasct_pkg::DIM-1];
	lasct_pkg::sym_t                   a_rd_q;
	lasct_pkg::sym_t                   b_rd_q;
	lasct_pkg::score_t                 h_rd_q;

	logic                              ov_q;
	lasct_pkg::pos_t                   o_row_q;
	lasct_pkg::pos_t                   o_col_q;
	lasct_pkg::score_t                 o_score_q;
	logic                              o_end_q;

	logic                              pair_acc;
	logic                              st_we;
	logic                              can_load;
	logic                              o_load;
	logic                              first_row;
	logic                              first_col;
	lasct_pkg::pos_t                   im1;
	lasct_pkg::pos_t                   jm1;
	lasct_pkg::pos_t                   rd_row;
	lasct_pkg::pos_t                   rd_col;
	lasct_pkg::addr_t                  raddr;
	lasct_pkg::addr_t                  waddr;
	lasct_pkg::pos_t                   n_next;

	logic signed [SW-1:0]              diag_add;
	logic signed [SW-1:0]              gap_ext;
	lasct_pkg::score_t                 up_val;
	logic signed [SW-1:0]              d_s;
	logic signed [SW-1:0]              up_s;
	logic signed [SW-1:0]              lf_s;
	logic signed [SW-1:0]              h_s;
	lasct_pkg::score_t                 h_new;

	lasct_pkg::score_t                 tu;
	lasct_pkg::score_t                 tm;
	logic                              t_last;

	assign pairs.ready = (state_q == S_IDLE);
	assign pair_acc    = pairs.valid && pairs.ready;
	assign st_we       = pair_acc && (cnt_q < lasct_pkg::CNT_W'(lasct_pkg::MAX_LEN));
	assign n_next      = st_we ? cnt_q + lasct_pkg::CNT_W'(1) : cnt_q;
	assign can_load    = !ov_q || cells.ready;
	assign o_load      = can_load && ((state_q == S_TE) || (state_q == S_ZERO));

	assign first_row = (i_q == lasct_pkg::CNT_W'(1));
	assign first_col = (j_q == lasct_pkg::CNT_W'(1));
	assign im1       = i_q - lasct_pkg::CNT_W'(1);
	assign jm1       = j_q - lasct_pkg::CNT_W'(1);

	// read port address per state
	always_comb begin
		rd_row = im1;
		rd_col = j_q;
		case (state_q)
			S_TD: begin
				rd_row = im1;
				rd_col = jm1;
			end
			S_TL: begin
				rd_row = i_q;
				rd_col = jm1;
			end
			default: begin
				rd_row = im1;
				rd_col = j_q;
			end
		endcase
	end

	assign raddr = lasct_pkg::cell_addr(rd_row, rd_col);
	assign waddr = lasct_pkg::cell_addr(i_q, j_q);

	// cell update: max(0, diag + sub, up + gap, left + gap)
	always_comb begin
		diag_add = (a_rd_q == b_rd_q) ? $signed({{(SW-4){1'b0}}, match_q})
			: $signed({{(SW-lasct_pkg::CFG_W){mism_q[lasct_pkg::CFG_W-1]}}, mism_q});
		gap_ext  = $signed({{(SW-lasct_pkg::CFG_W){gap_q[lasct_pkg::CFG_W-1]}}, gap_q});
		up_val   = first_row ? '0 : h_rd_q;
		d_s      = $signed({2'b00, diag_q}) + diag_add;
		up_s     = $signed({2'b00, up_val}) + gap_ext;
		lf_s     = $signed({2'b00, left_q}) + gap_ext;
		h_s      = '0;
		if (d_s > h_s) h_s = d_s;
		if (up_s > h_s) h_s = up_s;
		if (lf_s > h_s) h_s = lf_s;
		h_new    = h_s[lasct_pkg::SCORE_W-1:0];
	end

	// traceback step: greatest neighbor, diagonal then left then up on ties
	always_comb begin
		tu = first_row ? '0 : h_rd_q;
		tm = td_q;
		if (tl_q > tm) tm = tl_q;
		if (tu > tm) tm = tu;
		t_last = (tm == '0);
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			a_mem[cnt_q[lasct_pkg::IDX_W-1:0]] <= pairs.symbol_first;
			b_mem[cnt_q[lasct_pkg::IDX_W-1:0]] <= pairs.symbol_second;
		end
		a_rd_q <= a_mem[im1[lasct_pkg::IDX_W-1:0]];
		b_rd_q <= b_mem[jm1[lasct_pkg::IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FWR) begin
			h_mem[waddr] <= h_new;
		end
		h_rd_q <= h_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 4'd2;
			mism_q  <= '1;
			gap_q   <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				lasct_pkg::REG_MATCH:    match_q <= cfg_data[3:0];
				lasct_pkg::REG_MISMATCH: mism_q  <= cfg_data;
				lasct_pkg::REG_GAP:      gap_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			n_q        <= '0;
			i_q        <= '0;
			j_q        <= '0;
			diag_q     <= '0;
			left_q     <= '0;
			best_q     <= '0;
			best_row_q <= '0;
			best_col_q <= '0;
			cur_q      <= '0;
			td_q       <= '0;
			tl_q       <= '0;
			ov_q       <= 1'b0;
			o_row_q    <= '0;
			o_col_q    <= '0;
			o_score_q  <= '0;
			o_end_q    <= 1'b0;
		end else begin
			if (o_load) begin
				ov_q <= 1'b1;
			end else if (cells.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pair_acc) begin
						if (pairs.final_pair) begin
							n_q     <= n_next;
							cnt_q   <= '0;
							i_q     <= lasct_pkg::CNT_W'(1);
							j_q     <= lasct_pkg::CNT_W'(1);
							diag_q  <= '0;
							left_q  <= '0;
							best_q  <= '0;
							best_row_q <= '0;
							best_col_q <= '0;
							state_q <= S_FRD;
						end else begin
							cnt_q <= n_next;
						end
					end
				end
				S_FRD: begin
					state_q <= S_FWR;
				end
				S_FWR: begin
					if (h_new > best_q) begin
						best_q     <= h_new;
						best_row_q <= i_q;
						best_col_q <= j_q;
					end
					if (j_q == n_q) begin
						diag_q  <= '0;
						left_q  <= '0;
						j_q     <= lasct_pkg::CNT_W'(1);
						i_q     <= i_q + lasct_pkg::CNT_W'(1);
						state_q <= (i_q == n_q) ? S_TSEL : S_FRD;
					end else begin
						diag_q  <= up_val;
						left_q  <= h_new;
						j_q     <= j_q + lasct_pkg::CNT_W'(1);
						state_q <= S_FRD;
					end
				end
				S_TSEL: begin
					if (best_q == '0) begin
						state_q <= S_ZERO;
					end else begin
						i_q     <= best_row_q;
						j_q     <= best_col_q;
						cur_q   <= best_q;
						state_q <= S_TD;
					end
				end
				S_TD: begin
					state_q <= S_TL;
				end
				S_TL: begin
					td_q    <= (first_row || first_col) ? '0 : h_rd_q;
					state_q <= S_TU;
				end
				S_TU: begin
					tl_q    <= first_col ? '0 : h_rd_q;
					state_q <= S_TE;
				end
				S_TE: begin
					if (can_load) begin
						o_row_q   <= i_q;
						o_col_q   <= j_q;
						o_score_q <= cur_q;
						o_end_q   <= t_last;
						cur_q     <= tm;
						if (t_last) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_TD;
							if (tm == td_q) begin
								i_q <= im1;
								j_q <= jm1;
							end else if (tm == tl_q) begin
								j_q <= jm1;
							end else begin
								i_q <= im1;
							end
						end
					end
				end
				S_ZERO: begin
					if (can_load) begin
						o_row_q   <= '0;
						o_col_q   <= '0;
						o_score_q <= '0;
						o_end_q   <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cells.valid      = ov_q;
	assign cells.path_row   = o_row_q;
	assign cells.path_col   = o_col_q;
	assign cells.cell_score = o_score_q;
	assign cells.path_end   = o_end_q;

	`CHK_ALWAYS(a_cnt_bound, cnt_q <= lasct_pkg::CNT_W'(lasct_pkg::MAX_LEN), "load count over MAX_LEN")
	`CHK_IMPL(a_fill_range, state_q == S_FWR, i_q != '0 && j_q != '0 && i_q <= n_q && j_q <= n_q, "fill cell outside matrix")
	`CHK_IMPL(a_trace_range, state_q == S_TE, i_q != '0 && j_q != '0, "traceback left the matrix")
	`CHK_IMPL(a_path_score, cells.valid && !cells.path_end, cells.cell_score != '0, "zero cell inside a path")

endmodule

### tb/local_alignment_scorer_traceback_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// local_alignment_scorer_traceback_checker
// Watches the pair, cell and register ports, rebuilds each score matrix and
// its traceback, and compares every traceback word in order.
// ----------------------------------------------------------------------------
module local_alignment_scorer_traceback_checker
	import lasct_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	lasct_pair_if             pairs,
	lasct_cell_if             cells,
	input  logic              cfg_we,
	input  logic [CFGI_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	output int                fails,
	output int                pending,
	output int                words_checked
);

	localparam int MAX_WORDS = 64;

	typedef struct {
		pos_t   row;
		pos_t   col;
		score_t score;
		logic   last;
	} path_word_t;

	path_word_t        expected_path[$];
	sym_t              first_seq[MAX_LEN];
	sym_t              second_seq[MAX_LEN];
	int                held;
	int                fail_count;
	int                checked;
	logic [3:0]        match_val;
	logic signed [4:0] mismatch_val;
	logic signed [4:0] gap_val;

	function automatic int bigger(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	task automatic align_and_trace(input int n);
		int         h[DIM][DIM];
		int         best, bi, bj, d, up, left, m, i, j, k;
		path_word_t w;
		best = 0;
		bi = 0;
		bj = 0;
		for (i = 0; i < DIM; i++)
			for (j = 0; j < DIM; j++)
				h[i][j] = 0;
		for (i = 1; i <= n; i++) begin
			for (j = 1; j <= n; j++) begin
				d = h[i-1][j-1] + ((first_seq[i-1] == second_seq[j-1]) ?
					int'(match_val) : int'(mismatch_val));
				up = h[i-1][j] + int'(gap_val);
				left = h[i][j-1] + int'(gap_val);
				h[i][j] = bigger(bigger(0, d), bigger(up, left));
				if (h[i][j] > best) begin
					best = h[i][j];
					bi = i;
					bj = j;
				end
			end
		end
		if (best == 0) begin
			w.row = '0;
			w.col = '0;
			w.score = '0;
			w.last = 1'b1;
			expected_path.insert(expected_path.size(), w);
			return;
		end
		i = bi;
		j = bj;
		for (k = 0; k < MAX_WORDS; k++) begin
			d = h[i-1][j-1];
			left = h[i][j-1];
			up = h[i-1][j];
			m = bigger(bigger(d, left), up);
			w.row = pos_t'(i);
			w.col = pos_t'(j);
			w.score = score_t'(h[i][j]);
			w.last = (m == 0) || (k == MAX_WORDS - 1);
			expected_path.insert(expected_path.size(), w);
			if (w.last)
				break;
			// ties: diagonal, then left, then up
			if (m == d) begin
				i--;
				j--;
			end else if (m == left) begin
				j--;
			end else begin
				i--;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		path_word_t want;
		if (!arst_n) begin
			held = 0;
			fail_count = 0;
			checked = 0;
			match_val = 4'd2;
			mismatch_val = -5'sd1;
			gap_val = -5'sd1;
			expected_path.delete();
			fails <= 0;
			pending <= 0;
			words_checked <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MATCH:    match_val = cfg_data[3:0];
					REG_MISMATCH: mismatch_val = cfg_data;
					REG_GAP:      gap_val = cfg_data;
					default:      ;
				endcase
			end
			if (pairs.valid && pairs.ready) begin
				// pairs past MAX_LEN are dropped
				if (held < MAX_LEN) begin
					first_seq[held] = pairs.symbol_first;
					second_seq[held] = pairs.symbol_second;
					held++;
				end
				if (pairs.final_pair) begin
					align_and_trace(held);
					held = 0;
				end
			end
			if (cells.valid && cells.ready) begin
				if (expected_path.size() == 0) begin
					$error("unexpected traceback word: row %0d col %0d score %0d end %0b",
						cells.path_row, cells.path_col, cells.cell_score, cells.path_end);
					fail_count++;
				end else begin
					want = expected_path.pop_front();
					checked++;
					if (cells.path_row !== want.row) begin
						$error("path_row: expected %0d, actual %0d", want.row, cells.path_row);
						fail_count++;
					end
					if (cells.path_col !== want.col) begin
						$error("path_col: expected %0d, actual %0d", want.col, cells.path_col);
						fail_count++;
					end
					if (cells.cell_score !== want.score) begin
						$error("cell_score: expected %0d, actual %0d", want.score,
							cells.cell_score);
						fail_count++;
					end
					if (cells.path_end !== want.last) begin
						$error("path_end: expected %0b, actual %0b", want.last, cells.path_end);
						fail_count++;
					end
				end
			end
			pending <= expected_path.size();
			fails <= fail_count;
			words_checked <= checked;
		end
	end

endmodule

### tb/local_alignment_scorer_traceback_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// local_alignment_scorer_traceback_tb
// Loads symbol pair sequences under several scoring settings, with random
// gaps on both channels, a long output stall and overfull loads; the checker
// predicts every traceback word and counts mismatches.
// ----------------------------------------------------------------------------
module local_alignment_scorer_traceback_tb;
	import lasct_pkg::*;

	localparam logic [CFGI_W-1:0] REG_SPARE = 2'd3;
	localparam int IDLE_PCT      = 14;
	localparam int HOLD_CYCLES   = 600;
	localparam int STALL_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 16;
	localparam int NUM_PHASES    = 6;
	localparam int PHASE_ITEMS   = 30;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CFGI_W-1:0] cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	int                fails;
	int                pending;
	int                words_checked;
	int                pairs_sent;
	int                loads_sent;
	int                settings_used;
	int                quiet_cycles;
	bit                calm;
	bit                hold_req;

	lasct_pair_if pairs_bus ();
	lasct_cell_if cells_bus ();

	local_alignment_scorer_traceback i_dut (
		.clk,
		.arst_n,
		.pairs     (pairs_bus),
		.cells     (cells_bus),
		.cfg_we,
		.cfg_index,
		.cfg_data
	);

	local_alignment_scorer_traceback_checker i_checker (
		.clk,
		.arst_n,
		.pairs         (pairs_bus),
		.cells         (cells_bus),
		.cfg_we,
		.cfg_index,
		.cfg_data,
		.fails,
		.pending,
		.words_checked
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// traceback receiver: random stalls, one long hold-off on request
	initial begin
		cells_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				cells_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			cells_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if (!arst_n || (pairs_bus.valid && pairs_bus.ready) ||
					(cells_bus.valid && cells_bus.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("local_alignment_scorer_traceback: mismatch");
				$finish;
			end
		end
	end

	task automatic send_pair(input sym_t a, input sym_t b, input logic fin);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			pairs_bus.valid <= 1'b0;
			@(posedge clk);
		end
		pairs_bus.valid <= 1'b1;
		pairs_bus.symbol_first <= a;
		pairs_bus.symbol_second <= b;
		pairs_bus.final_pair <= fin;
		do @(posedge clk); while (pairs_bus.ready !== 1'b1);
		pairs_sent++;
	endtask

	task automatic send_load(input int n, input int alphabet, input int copy_pct);
		sym_t base, a, b;
		int   p;
		base = sym_t'($urandom_range(255));
		for (p = 0; p < n; p++) begin
			a = base + sym_t'($urandom_range(alphabet - 1));
			if ($urandom_range(99) < copy_pct)
				b = a;
			else
				b = base + sym_t'($urandom_range(alphabet - 1));
			send_pair(a, b, p == n - 1);
		end
		loads_sent++;
	endtask

	// sender holds off until every traceback word is back, then the block idles
	task automatic drain_and_settle();
		pairs_bus.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] mm,
			input logic [CFG_W-1:0] g, input bit poke_spare);
		cfg_we <= 1'b1;
		cfg_index <= REG_MATCH;
		cfg_data <= m;
		@(posedge clk);
		cfg_index <= REG_MISMATCH;
		cfg_data <= mm;
		@(posedge clk);
		cfg_index <= REG_GAP;
		cfg_data <= g;
		@(posedge clk);
		if (poke_spare) begin
			cfg_index <= REG_SPARE;
			cfg_data <= '1;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin
		int n, alphabet, copy_pct, phase_items, loads_in_phase, r;
		logic [CFG_W-1:0] mval, mmval, gval;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pairs_bus.valid = 1'b0;
		pairs_bus.symbol_first = '0;
		pairs_bus.symbol_second = '0;
		pairs_bus.final_pair = 1'b0;
		calm = 1'b0;
		hold_req = 1'b0;
		pairs_sent = 0;
		loads_sent = 0;
		settings_used = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed loads under reset scoring
		send_pair(8'd255, 8'd255, 1'b1);
		send_pair(8'd0, 8'd255, 1'b1);
		send_pair(8'd0, 8'd0, 1'b0);
		send_pair(8'd255, 8'd255, 1'b0);
		send_pair(8'd170, 8'd85, 1'b1);
		send_pair(8'd1, 8'd2, 1'b0);
		send_pair(8'd2, 8'd1, 1'b0);
		send_pair(8'd1, 8'd2, 1'b0);
		send_pair(8'd2, 8'd1, 1'b1);
		send_pair(8'd7, 8'd7, 1'b0);
		send_pair(8'd8, 8'd9, 1'b0);
		send_pair(8'd9, 8'd8, 1'b0);
		send_pair(8'd7, 8'd7, 1'b0);
		send_pair(8'd85, 8'd170, 1'b1);
		send_pair(8'd128, 8'd128, 1'b0);
		send_pair(8'd127, 8'd127, 1'b1);
		loads_sent += 6;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain_and_settle();
			case (ph)
				0: write_regs(5'd15, 5'd0, 5'd0, 1'b1);
				1: write_regs(5'd0, -5'sd15, -5'sd15, 1'b0);
				2: write_regs(5'h13, -5'sd15, 5'd0, 1'b0); // match keeps low 4 bits
				5: write_regs(5'd2, -5'sd1, -5'sd1, 1'b0);
				default: begin
					mval = CFG_W'($urandom_range(31));
					mmval = CFG_W'(0 - int'($urandom_range(15)));
					gval = CFG_W'(0 - int'($urandom_range(15)));
					write_regs(mval, mmval, gval, 1'b0);
				end
			endcase
			calm = (ph == 4);
			phase_items = 0;
			loads_in_phase = 0;
			while (phase_items < PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < 65)
					n = $urandom_range(5, 1);
				else if (r < 88)
					n = $urandom_range(12, 6);
				else if (r < 96)
					n = $urandom_range(MAX_LEN - 1, 13);
				else
					n = $urandom_range(MAX_LEN + 6, MAX_LEN);
				r = $urandom_range(3);
				alphabet = (r < 2) ? 4 : ((r == 2) ? 16 : 256);
				copy_pct = $urandom_range(90);
				// top score: one repeated symbol over a full store
				if (ph == 0 && loads_in_phase == 1) begin
					n = MAX_LEN;
					alphabet = 1;
					copy_pct = 100;
				end
				if (ph == 2 && loads_in_phase == 0)
					n = MAX_LEN + 4;
				if (ph == 3 && loads_in_phase == 1)
					hold_req = 1'b1;
				send_load(n, alphabet, copy_pct);
				phase_items += n;
				loads_in_phase++;
			end
		end
		drain_and_settle();
		calm = 1'b0;

		$display("checked %0d traceback words from %0d loads of %0d symbol pairs",
			words_checked, loads_sent, pairs_sent);
		$display("over %0d scoring settings, with overfull loads and a long output stall",
			settings_used);
		if (fails == 0 && pending == 0) begin
			$display("local_alignment_scorer_traceback: match");
		end else begin
			$display("local_alignment_scorer_traceback: mismatch");
		end
		$finish;
	end

endmodule
